// ----- hdl/unicode_rich_string_parser_top_defines.svh -----
// Assertion macros shared by the string parser RTL.
`ifndef UNICODE_RICH_STRING_PARSER_TOP_DEFINES_SVH
`define UNICODE_RICH_STRING_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ursp_pkg.sv -----
package ursp_pkg;

  // Width of the character counter; the count field itself is 16 bits.
  localparam int COUNT_WIDTH = 16;
  localparam int CHAR_BITS   = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam logic [CHAR_BITS-1:0] CHARS_ONE = {{(CHAR_BITS-1){1'b0}}, 1'b1};

  // Running size saturates one above the largest 16-bit limit.
  localparam logic [16:0] SIZE_SAT = 17'h10000;

  // Flags byte bits.
  localparam logic [7:0] FLAG_WIDE     = 8'h01;
  localparam logic [7:0] FLAG_PHONETIC = 8'h04;
  localparam logic [7:0] FLAG_RICH     = 8'h08;

  // Header field lengths in bytes.
  localparam logic [2:0] RUNS_BYTES = 3'd2;
  localparam logic [2:0] PHON_BYTES = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RUNS,
    PH_PHON,
    PH_LO,
    PH_HI,
    PH_OPT
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        start_req;
    logic [15:0] char_count;
    logic [15:0] max_size;
    logic [15:0] continue_pos;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    logic        last;
    logic        error;
    logic [15:0] bytes_used;
  } out_item_t;

endpackage

// ----- hdl/ursp_in_if.sv -----
interface ursp_in_if;
  logic             valid;
  logic             ready;
  ursp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ursp_out_if.sv -----
interface ursp_out_if;
  logic              valid;
  logic              ready;
  ursp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/unicode_rich_string_parser_top.sv -----
// A byte's result passes through the input register and then the result register.
// Throughput: one stream byte per cycle while results are taken; the input and
// result registers each take a new item whenever the stage after them moves on.
// Bytes that give no result pass through the input register and leave no output.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to idle with all counters cleared.
`include "unicode_rich_string_parser_top_defines.svh"

module unicode_rich_string_parser_top (
  input logic          clk,
  input logic          rst,
  ursp_in_if.sink      stream,
  ursp_out_if.source   result
);

  // Input register.
  logic               s1_valid;
  ursp_pkg::in_item_t s1_item;
  logic               s1_fire;

  // Result register.
  logic                out_valid;
  ursp_pkg::out_item_t out_item;

  // Parser state.
  ursp_pkg::phase_t              phase, phase_next;
  logic [15:0]                   byte_offset, byte_offset_next;
  logic [16:0]                   size_total, size_total_next;
  logic [ursp_pkg::CHAR_BITS-1:0] chars_left, chars_left_next;
  logic                          wide_chars, wide_chars_next;
  logic [1:0]                    header_flags, header_flags_next;
  logic [2:0]                    header_bytes_left, header_bytes_left_next;
  logic [31:0]                   header_accum, header_accum_next;
  logic [7:0]                    low_byte, low_byte_next;
  logic [15:0]                   limit_size, limit_size_next;
  logic [15:0]                   limit_continue, limit_continue_next;

  // Step outcome.
  logic                res_valid;
  ursp_pkg::out_item_t res;
  logic                do_finish;
  logic                do_fail;
  logic                emit_ch;
  logic [1:0]          ch_w;
  logic [15:0]         ch_cu;
  logic [3:0]          need;
  logic [2:0]          hdr_total;
  logic [1:0]          hdr_idx;
  logic [17:0]         char_need;

  function automatic logic [16:0] sat_add(input logic [16:0] s, input logic [32:0] v);
    logic [33:0] sum;
    sum = {17'b0, s} + {1'b0, v};
    return (sum > {17'b0, ursp_pkg::SIZE_SAT}) ? ursp_pkg::SIZE_SAT : sum[16:0];
  endfunction

  // Handshakes: the input register drains into the result register.
  assign s1_fire        = s1_valid && (!out_valid || result.ready);
  assign stream.ready   = !s1_valid || s1_fire;
  assign result.valid   = out_valid;
  assign result.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
    if (stream.valid && stream.ready) begin
      s1_item <= stream.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && res_valid) begin
      out_item <= res;
    end
  end

  // State register, updated once per byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ursp_pkg::PH_IDLE;
      byte_offset       <= '0;
      size_total        <= '0;
      chars_left        <= '0;
      wide_chars        <= 1'b0;
      header_flags      <= '0;
      header_bytes_left <= '0;
      header_accum      <= '0;
      low_byte          <= '0;
      limit_size        <= '0;
      limit_continue    <= '0;
    end else if (s1_fire) begin
      phase             <= phase_next;
      byte_offset       <= byte_offset_next;
      size_total        <= size_total_next;
      chars_left        <= chars_left_next;
      wide_chars        <= wide_chars_next;
      header_flags      <= header_flags_next;
      header_bytes_left <= header_bytes_left_next;
      header_accum      <= header_accum_next;
      low_byte          <= low_byte_next;
      limit_size        <= limit_size_next;
      limit_continue    <= limit_continue_next;
    end
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_next             = phase;
    byte_offset_next       = byte_offset;
    size_total_next        = size_total;
    chars_left_next        = chars_left;
    wide_chars_next        = wide_chars;
    header_flags_next      = header_flags;
    header_bytes_left_next = header_bytes_left;
    header_accum_next      = header_accum;
    low_byte_next          = low_byte;
    limit_size_next        = limit_size;
    limit_continue_next    = limit_continue;
    res_valid = 1'b0;
    res       = '0;
    do_finish = 1'b0;
    do_fail   = 1'b0;
    emit_ch   = 1'b0;
    ch_w      = 2'd1;
    ch_cu     = '0;
    need      = 4'd1 + ((|(s1_item.byte_value & ursp_pkg::FLAG_RICH)) ? 4'd2 : 4'd0)
                + ((|(s1_item.byte_value & ursp_pkg::FLAG_PHONETIC)) ? 4'd4 : 4'd0);
    hdr_total = (phase == ursp_pkg::PH_RUNS) ? ursp_pkg::RUNS_BYTES : ursp_pkg::PHON_BYTES;
    hdr_idx   = 2'(hdr_total - header_bytes_left);
    char_need = {1'b0, size_total} + (wide_chars ? 18'd2 : 18'd1);

    if (s1_item.start_req) begin
      // Flags byte: sample the limits and check the header fits.
      limit_size_next        = s1_item.max_size;
      limit_continue_next    = s1_item.continue_pos;
      chars_left_next        = s1_item.char_count[ursp_pkg::CHAR_BITS-1:0];
      wide_chars_next        = |(s1_item.byte_value & ursp_pkg::FLAG_WIDE);
      header_flags_next      = {|(s1_item.byte_value & ursp_pkg::FLAG_PHONETIC),
                                |(s1_item.byte_value & ursp_pkg::FLAG_RICH)};
      byte_offset_next       = 16'd1;
      size_total_next        = 17'd1;
      header_accum_next      = '0;
      header_bytes_left_next = '0;
      if (s1_item.max_size < {12'b0, need}) begin
        do_fail = 1'b1;
      end else if (header_flags_next[0]) begin
        phase_next             = ursp_pkg::PH_RUNS;
        header_bytes_left_next = ursp_pkg::RUNS_BYTES;
      end else if (header_flags_next[1]) begin
        phase_next             = ursp_pkg::PH_PHON;
        header_bytes_left_next = ursp_pkg::PHON_BYTES;
      end else begin
        do_finish = 1'b1;
      end
    end else begin
      unique case (phase)
        ursp_pkg::PH_IDLE: begin
          // Bytes between strings are dropped.
        end
        ursp_pkg::PH_RUNS, ursp_pkg::PH_PHON: begin
          header_accum_next[{hdr_idx, 3'b000} +: 8] = s1_item.byte_value;
          byte_offset_next       = byte_offset + 16'd1;
          header_bytes_left_next = header_bytes_left - 3'd1;
          if (header_bytes_left_next != 3'd0) begin
            size_total_next = sat_add(size_total, 33'd1);
          end else if (phase == ursp_pkg::PH_RUNS) begin
            // Four bytes per rich run, plus this header byte.
            size_total_next   = sat_add(size_total,
                                  {15'b0, s1_item.byte_value, header_accum[7:0], 2'b00}
                                  + 33'd1);
            header_flags_next = {header_flags[1], 1'b0};
            header_accum_next = '0;
            if (header_flags[1]) begin
              phase_next             = ursp_pkg::PH_PHON;
              header_bytes_left_next = ursp_pkg::PHON_BYTES;
            end else begin
              do_finish = 1'b1;
            end
          end else begin
            size_total_next   = sat_add(size_total,
                                  {1'b0, s1_item.byte_value, header_accum[23:0]} + 33'd1);
            header_flags_next = '0;
            header_accum_next = '0;
            do_finish         = 1'b1;
          end
        end
        ursp_pkg::PH_LO: begin
          if (char_need > {2'b0, limit_size}) begin
            do_fail = 1'b1;
          end else if (wide_chars) begin
            low_byte_next = s1_item.byte_value;
            phase_next    = ursp_pkg::PH_HI;
          end else begin
            emit_ch = 1'b1;
            ch_w    = 2'd1;
            ch_cu   = {8'b0, s1_item.byte_value};
          end
        end
        ursp_pkg::PH_HI: begin
          emit_ch = 1'b1;
          ch_w    = 2'd2;
          ch_cu   = {s1_item.byte_value, low_byte};
        end
        ursp_pkg::PH_OPT: begin
          if ({1'b0, size_total} + 18'd1 > {2'b0, limit_size}) begin
            do_fail = 1'b1;
          end else begin
            wide_chars_next  = |(s1_item.byte_value & ursp_pkg::FLAG_WIDE);
            size_total_next  = sat_add(size_total, 33'd1);
            byte_offset_next = byte_offset + 16'd1;
            phase_next       = ursp_pkg::PH_LO;
          end
        end
        default: begin
          phase_next = ursp_pkg::PH_IDLE;
        end
      endcase
    end

    // End of header: size check, then an empty string ends here.
    if (do_finish) begin
      if (size_total_next > {1'b0, limit_size_next}) begin
        do_fail = 1'b1;
      end else if (chars_left_next == '0) begin
        phase_next     = ursp_pkg::PH_IDLE;
        res_valid      = 1'b1;
        res.last       = 1'b1;
        res.bytes_used = size_total_next[15:0];
      end else begin
        phase_next = ursp_pkg::PH_LO;
      end
    end

    // A complete character is emitted.
    if (emit_ch) begin
      byte_offset_next = byte_offset + {14'b0, ch_w};
      size_total_next  = sat_add(size_total, {31'b0, ch_w});
      chars_left_next  = chars_left - ursp_pkg::CHARS_ONE;
      res_valid        = 1'b1;
      res.code_unit    = ch_cu;
      res.has_char     = 1'b1;
      if (chars_left_next == '0) begin
        phase_next     = ursp_pkg::PH_IDLE;
        res.last       = 1'b1;
        res.bytes_used = size_total_next[15:0];
      end else if (byte_offset_next == limit_continue) begin
        phase_next = ursp_pkg::PH_OPT;
      end else begin
        phase_next = ursp_pkg::PH_LO;
      end
    end

    // Bound exceeded: abort the string with an error result.
    if (do_fail) begin
      phase_next = ursp_pkg::PH_IDLE;
      res_valid  = 1'b1;
      res        = '0;
      res.last   = 1'b1;
      res.error  = 1'b1;
    end
  end

  // Checks on the parser's own logic.
  `URSP_ASSERT_SAME(a_error_is_final, out_valid && out_item.error,
                    out_item.last && !out_item.has_char, "error result not a bare final result")
  `URSP_ASSERT_NEXT(a_last_goes_idle, s1_fire && res_valid && res.last,
                    phase == ursp_pkg::PH_IDLE, "parser not idle after final result")
  `URSP_ASSERT_SAME(a_high_byte_wide, phase == ursp_pkg::PH_HI, wide_chars,
                    "high byte expected while characters are narrow")
  `URSP_ASSERT_SAME(a_size_nonzero, out_valid && out_item.last && !out_item.error,
                    out_item.bytes_used != 16'd0, "finished string reports zero size")

endmodule

// ----- dv/unicode_rich_string_parser_top_tb.sv -----
module unicode_rich_string_parser_top_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ROW_TARGET    = 1300;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_SPAN     = 80;
  localparam int DRAIN_AT      = 900;
  localparam int CALM_TAIL     = 200;
  localparam int SETTLE_CYCLES = 20;

  // One stimulus byte, optionally with its outcome typed in by hand.
  typedef struct packed {
    ursp_pkg::in_item_t  item;
    logic                pinned;
    logic                gives;
    ursp_pkg::out_item_t want;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ursp_in_if  stream_if ();
  ursp_out_if result_if ();

  unicode_rich_string_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always #2 clk = ~clk;

  byte_row_t           byte_rows[$];
  ursp_pkg::out_item_t units_due[$];
  int        bad_fields  = 0;
  int        bytes_sent  = 0;
  int        cycle_count = 0;
  int        hold_left   = 0;
  int        stall_left  = 0;
  bit        hold_done   = 1'b0;
  bit        calm        = 1'b0;

  // Parser state as the predictor sees it.
  ursp_pkg::phase_t pr_phase;
  logic [15:0] pr_offset;
  logic [16:0] pr_size;
  logic [15:0] pr_left;
  logic        pr_wide;
  logic        pr_need_runs;
  logic        pr_need_phon;
  logic [2:0]  pr_hleft;
  logic [31:0] pr_accum;
  logic [7:0]  pr_low;
  logic [15:0] pr_limit;
  logic [15:0] pr_cont;

  function automatic ursp_pkg::out_item_t result_of(logic [15:0] cu, logic hc, logic fin,
                                                    logic bad, logic [15:0] used);
    ursp_pkg::out_item_t r;
    r.code_unit  = cu;
    r.has_char   = hc;
    r.last       = fin;
    r.error      = bad;
    r.bytes_used = used;
    return r;
  endfunction

  function automatic void parser_reset();
    pr_phase     = ursp_pkg::PH_IDLE;
    pr_offset    = '0;
    pr_size      = '0;
    pr_left      = '0;
    pr_wide      = 1'b0;
    pr_need_runs = 1'b0;
    pr_need_phon = 1'b0;
    pr_hleft     = '0;
    pr_accum     = '0;
    pr_low       = '0;
    pr_limit     = '0;
    pr_cont      = '0;
  endfunction

  // The running size sticks at one above the largest limit.
  function automatic void grow_size(longint unsigned v);
    longint unsigned s;
    s = longint'(pr_size) + v;
    pr_size = (s > ursp_pkg::SIZE_SAT) ? ursp_pkg::SIZE_SAT : s[16:0];
  endfunction

  function automatic bit string_error(output ursp_pkg::out_item_t r);
    pr_phase = ursp_pkg::PH_IDLE;
    r = result_of(16'h0, 1'b0, 1'b1, 1'b1, 16'h0);
    return 1'b1;
  endfunction

  // End of the header: size check, then either an empty string or the characters.
  function automatic bit header_done(output ursp_pkg::out_item_t r);
    r = '0;
    if (pr_size > pr_limit) return string_error(r);
    if (pr_left == 0) begin
      pr_phase = ursp_pkg::PH_IDLE;
      r = result_of(16'h0, 1'b0, 1'b1, 1'b0, pr_size[15:0]);
      return 1'b1;
    end
    pr_phase = ursp_pkg::PH_LO;
    return 1'b0;
  endfunction

  function automatic bit char_done(input logic [15:0] cu, input int unsigned w,
                                   output ursp_pkg::out_item_t r);
    pr_offset = pr_offset + 16'(w);
    grow_size(w);
    pr_left = pr_left - 16'd1;
    if (pr_left == 0) begin
      pr_phase = ursp_pkg::PH_IDLE;
      r = result_of(cu, 1'b1, 1'b1, 1'b0, pr_size[15:0]);
      return 1'b1;
    end
    pr_phase = (pr_offset == pr_cont) ? ursp_pkg::PH_OPT : ursp_pkg::PH_LO;
    r = result_of(cu, 1'b1, 1'b0, 1'b0, 16'h0);
    return 1'b1;
  endfunction

  // Advances the predicted parser by one stream byte; returns 1 when a result is due.
  function automatic bit parse_byte(input ursp_pkg::in_item_t it,
                                    output ursp_pkg::out_item_t r);
    int unsigned need;
    int unsigned width;
    int unsigned idx;
    r = '0;
    if (it.start_req) begin
      pr_limit     = it.max_size;
      pr_cont      = it.continue_pos;
      pr_left      = it.char_count;
      pr_wide      = (it.byte_value & ursp_pkg::FLAG_WIDE) != 0;
      pr_need_runs = (it.byte_value & ursp_pkg::FLAG_RICH) != 0;
      pr_need_phon = (it.byte_value & ursp_pkg::FLAG_PHONETIC) != 0;
      pr_offset    = 16'd1;
      pr_size      = 17'd1;
      pr_accum     = '0;
      pr_hleft     = '0;
      need         = 1;
      if (pr_limit == 0) return string_error(r);
      if (pr_need_runs) begin
        need += ursp_pkg::RUNS_BYTES;
        if (need > pr_limit) return string_error(r);
      end
      if (pr_need_phon) begin
        need += ursp_pkg::PHON_BYTES;
        if (need > pr_limit) return string_error(r);
      end
      if (pr_need_runs) begin
        pr_phase = ursp_pkg::PH_RUNS;
        pr_hleft = ursp_pkg::RUNS_BYTES;
        return 1'b0;
      end
      if (pr_need_phon) begin
        pr_phase = ursp_pkg::PH_PHON;
        pr_hleft = ursp_pkg::PHON_BYTES;
        return 1'b0;
      end
      return header_done(r);
    end

    case (pr_phase)
      ursp_pkg::PH_RUNS, ursp_pkg::PH_PHON: begin
        idx = ((pr_phase == ursp_pkg::PH_RUNS) ? ursp_pkg::RUNS_BYTES
                                               : ursp_pkg::PHON_BYTES) - pr_hleft;
        pr_accum |= 32'(it.byte_value) << (8 * (idx & 3));
        pr_offset = pr_offset + 16'd1;
        grow_size(1);
        pr_hleft = pr_hleft - 3'd1;
        if (pr_hleft != 0) return 1'b0;
        if (pr_phase == ursp_pkg::PH_RUNS) begin
          // Each rich run takes four bytes.
          grow_size(longint'(pr_accum) * 4);
          pr_need_runs = 1'b0;
          pr_accum = '0;
          if (pr_need_phon) begin
            pr_phase = ursp_pkg::PH_PHON;
            pr_hleft = ursp_pkg::PHON_BYTES;
            return 1'b0;
          end
        end else begin
          grow_size(longint'(pr_accum));
          pr_need_runs = 1'b0;
          pr_need_phon = 1'b0;
          pr_accum = '0;
        end
        return header_done(r);
      end
      ursp_pkg::PH_LO: begin
        width = pr_wide ? 2 : 1;
        if (pr_size + width > pr_limit) return string_error(r);
        if (pr_wide) begin
          pr_low = it.byte_value;
          pr_phase = ursp_pkg::PH_HI;
          return 1'b0;
        end
        return char_done(16'(it.byte_value), 1, r);
      end
      ursp_pkg::PH_HI: return char_done({it.byte_value, pr_low}, 2, r);
      ursp_pkg::PH_OPT: begin
        if (pr_size + 1 > pr_limit) return string_error(r);
        pr_wide = it.byte_value[0];
        grow_size(1);
        pr_offset = pr_offset + 16'd1;
        pr_phase = ursp_pkg::PH_LO;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_start(logic [7:0] flags, logic [15:0] count,
                                     logic [15:0] limit, logic [15:0] cont);
    byte_row_t row;
    row = '0;
    row.item.byte_value   = flags;
    row.item.start_req    = 1'b1;
    row.item.char_count   = count;
    row.item.max_size     = limit;
    row.item.continue_pos = cont;
    byte_rows.push_back(row);
  endfunction

  // Fields other than the byte are don't-care here, so they carry noise.
  function automatic void push_byte(logic [7:0] b);
    byte_row_t row;
    row = '0;
    row.item.byte_value   = b;
    row.item.start_req    = 1'b0;
    row.item.char_count   = 16'($urandom);
    row.item.max_size     = 16'($urandom);
    row.item.continue_pos = 16'($urandom);
    byte_rows.push_back(row);
  endfunction

  function automatic void pin(bit gives, ursp_pkg::out_item_t want);
    byte_row_t row;
    row = byte_rows.pop_back();
    row.pinned = 1'b1;
    row.gives  = gives;
    row.want   = want;
    byte_rows.push_back(row);
  endfunction

  // A string with random content: mostly well formed, sometimes cut short or oversized.
  function automatic void push_random_string();
    logic [7:0]      flags;
    logic [15:0]     runs;
    logic [15:0]     limit;
    logic [15:0]     cont;
    logic [31:0]     phon;
    int unsigned     count;
    int unsigned     width;
    int unsigned     hdr;
    int unsigned     body;
    int unsigned     pick;
    longint unsigned need;
    bit              aims_option;
    flags = 8'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 14) count = $urandom_range(0, 6);
    else if (pick < 18) count = $urandom_range(7, 30);
    else count = $urandom_range(0, 65535);
    runs = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    phon = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5);
    width = ((flags & ursp_pkg::FLAG_WIDE) != 0) ? 2 : 1;
    hdr = 1;
    if ((flags & ursp_pkg::FLAG_RICH) != 0) hdr += 2;
    if ((flags & ursp_pkg::FLAG_PHONETIC) != 0) hdr += 4;
    need = hdr + count * 2 + 1;
    if ((flags & ursp_pkg::FLAG_RICH) != 0) need += longint'(runs) * 4;
    if ((flags & ursp_pkg::FLAG_PHONETIC) != 0) need += longint'(phon);
    // Limits range from roomy to just too tight, plus a few arbitrary ones.
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: need += $urandom_range(0, 20);
      5, 6: need = (need > 4) ? need - $urandom_range(0, 4) : need;
      7: need = $urandom_range(0, 65535);
      8: need = 65535;
      default: need = $urandom_range(0, 8);
    endcase
    limit = (need > 65535) ? 16'hFFFF : 16'(need);
    aims_option = (count > 1) && ($urandom_range(0, 1) == 1);
    if (aims_option) cont = 16'(hdr + width * $urandom_range(1, count - 1));
    else cont = 16'($urandom);
    push_start(flags, 16'(count), limit, cont);
    if ((flags & ursp_pkg::FLAG_RICH) != 0) begin
      push_byte(runs[7:0]);
      push_byte(runs[15:8]);
    end
    if ((flags & ursp_pkg::FLAG_PHONETIC) != 0) begin
      for (int k = 0; k < 4; k++) push_byte(phon[8*k +: 8]);
    end
    if (count > 64) body = $urandom_range(0, 40);
    else body = count * width + (aims_option ? 1 : 0) + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
    repeat (body) push_byte(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end
  endfunction

  function automatic void build_stimulus();
    ursp_pkg::out_item_t aborted;
    aborted = result_of(16'h0, 1'b0, 1'b1, 1'b1, 16'h0);
    // A stray byte with no string open is dropped.
    push_byte(8'hFF);
    pin(1'b0, '0);
    // Zero limit fails on the flags byte.
    push_start(8'h00, 16'd5, 16'd0, 16'd0);
    pin(1'b1, aborted);
    // Run count header does not fit.
    push_start(ursp_pkg::FLAG_RICH, 16'd1, 16'd2, 16'd0);
    pin(1'b1, aborted);
    // Phonetic header does not fit behind the run count.
    push_start(ursp_pkg::FLAG_RICH | ursp_pkg::FLAG_PHONETIC, 16'd1, 16'd6, 16'd0);
    pin(1'b1, aborted);
    // Empty string ends on its flags byte.
    push_start(8'h00, 16'd0, 16'd1, 16'd0);
    pin(1'b1, result_of(16'h0, 1'b0, 1'b1, 1'b0, 16'd1));
    // Narrow string abandoned by a new start.
    push_start(8'h00, 16'd3, 16'hFFFF, 16'hFFFF);
    push_byte(8'hFF);
    pin(1'b1, result_of(16'h00FF, 1'b1, 1'b0, 1'b0, 16'h0));
    // Wide character that overruns the limit.
    push_start(ursp_pkg::FLAG_WIDE, 16'd1, 16'd2, 16'd0);
    push_byte(8'h00);
    pin(1'b1, aborted);
    // Option byte that overruns the limit.
    push_start(8'h00, 16'd2, 16'd2, 16'd2);
    push_byte(8'h61);
    push_byte(8'h01);
    pin(1'b1, aborted);
    // Both headers, a wide character, then an option byte switching to narrow.
    push_start(ursp_pkg::FLAG_WIDE | ursp_pkg::FLAG_PHONETIC | ursp_pkg::FLAG_RICH,
               16'd2, 16'hFFFF, 16'd9);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h03);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h34);
    push_byte(8'h12);
    push_byte(8'h00);
    push_byte(8'h41);
    // A huge phonetic size saturates the running size.
    push_start(ursp_pkg::FLAG_PHONETIC, 16'd1, 16'hFFFF, 16'd0);
    repeat (3) push_byte(8'hFF);
    push_byte(8'hFF);
    pin(1'b1, aborted);
    while (byte_rows.size() < ROW_TARGET) push_random_string();
  endfunction

  // Cycle counter guarding against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall bursts, and one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_sent >= HOLD_AT) begin
      result_if.ready <= 1'b0;
      hold_left <= HOLD_SPAN;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      result_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      result_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  task automatic note_bad(string what);
    bad_fields++;
    if (bad_fields <= 10) $display("mismatch: %s", what);
  endtask

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) note_bad($sformatf("%s expected %0h got %0h", field, want, got));
  endtask

  // Each result transfer is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    ursp_pkg::out_item_t want;
    ursp_pkg::out_item_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (units_due.size() == 0) begin
        note_bad($sformatf("unexpected result %0h", got));
      end else begin
        want = units_due.pop_front();
        check_field("code_unit", want.code_unit, got.code_unit);
        check_field("has_char", want.has_char, got.has_char);
        check_field("last", want.last, got.last);
        check_field("error", want.error, got.error);
        check_field("bytes_used", want.bytes_used, got.bytes_used);
      end
    end
  end

  // Stream side: walks the stimulus table and predicts each transferred byte.
  initial begin
    byte_row_t           row;
    ursp_pkg::out_item_t pred;
    stream_if.valid   = 1'b0;
    stream_if.payload = '0;
    parser_reset();
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < byte_rows.size(); i++) begin
      row = byte_rows[i];
      if (i >= byte_rows.size() - CALM_TAIL) calm = 1'b1;
      if (i == DRAIN_AT) begin
        // Let everything outstanding come out before going on.
        stream_if.valid <= 1'b0;
        do @(posedge clk); while (units_due.size() != 0);
      end else if (!calm && hold_left == 0 && $urandom_range(0, 5) == 0) begin
        stream_if.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      stream_if.valid   <= 1'b1;
      stream_if.payload <= row.item;
      do @(posedge clk); while (!stream_if.ready);
      bytes_sent++;
      if (row.pinned) begin
        void'(parse_byte(row.item, pred));
        if (row.gives) units_due.push_back(row.want);
      end else if (parse_byte(row.item, pred)) begin
        units_due.push_back(pred);
      end
    end
    stream_if.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    bad_fields += units_due.size();
    if (bad_fields == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ursp_pkg.sv
hdl/ursp_in_if.sv
hdl/ursp_out_if.sv
hdl/unicode_rich_string_parser_top.sv
dv/unicode_rich_string_parser_top_tb.sv
